// ===== hw/rtl/dsmfd_pkg.sv =====
// Shared types, constants and helper functions of the serial frame decoder.
// Used by dsmfd_frame_ram, dsmfd_ctrl and dsm_serial_frame_decoder_unit.
// Has no dependencies of its own.
package dsmfd_pkg;

  // Frame geometry.
  localparam int unsigned FrameBytes = 16;
  localparam int unsigned AddrW      = $clog2(FrameBytes);
  localparam int unsigned PosW       = AddrW + 1;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] GapLimitReset = 16'd5000;
  localparam logic [7:0]  MarkerByte    = 8'hE0;
  localparam logic [10:0] ScaleBase     = 11'd988;
  localparam logic [3:0]  HiChannels    = 4'd12;
  localparam logic [3:0]  LoChannels    = 4'd7;

  // Decode sequence: five header reads, then fourteen word bytes (2..15).
  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] StepFade  = 5'd0;
  localparam logic [StepW-1:0] StepB12   = 5'd1;
  localparam logic [StepW-1:0] StepB13   = 5'd2;
  localparam logic [StepW-1:0] StepB14   = 5'd3;
  localparam logic [StepW-1:0] StepB15   = 5'd4;
  localparam logic [StepW-1:0] StepWord0 = 5'd5;
  localparam logic [StepW-1:0] StepLast  = 5'd18;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHighRes  = 2'd0,
    CfgGapLimit = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCapture
  } state_e;

  // Port bundle from the controller to the frame memory.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic        slot;
    logic [3:0]  idx;
    logic [10:0] raw;
    logic [10:0] scaled;
  } word_t;

  // Frame address read at a given step of the decode sequence.
  function automatic logic [AddrW-1:0] step_addr(input logic [StepW-1:0] step);
    logic [StepW-1:0] wstep;
    logic [AddrW-1:0] addr;
    wstep = step - 5'd3;
    unique case (step)
      StepFade: addr = 4'd0;
      StepB12:  addr = 4'd12;
      StepB13:  addr = 4'd13;
      StepB14:  addr = 4'd14;
      StepB15:  addr = 4'd15;
      default:  addr = wstep[AddrW-1:0];
    endcase
    return addr;
  endfunction

  // Splits one two-byte channel word according to the resolution mode.
  function automatic word_t decode_word(input logic hires, input logic [7:0] hi,
                                        input logic [7:0] lo);
    word_t w;
    if (hires) begin
      w.idx    = hi[6:3];
      w.raw    = {hi[2:0], lo};
      w.slot   = (hi[6:3] < HiChannels);
      w.scaled = ScaleBase + {1'b0, w.raw[10:1]};
    end else begin
      w.idx    = hi[5:2];
      w.raw    = {1'b0, hi[1:0], lo};
      w.slot   = (hi[5:2] < LoChannels);
      w.scaled = ScaleBase + w.raw;
    end
    return w;
  endfunction

endpackage

// ===== hw/rtl/dsmfd_frame_ram.sv =====
// Sixteen-byte frame memory: one write port, one read port, registered read data.
// Depends on dsmfd_pkg for the geometry and the port bundle.
module dsmfd_frame_ram (
  input  logic                clk_i,
  input  dsmfd_pkg::ram_req_t req_i,
  output logic [7:0]          rdata_o
);
  import dsmfd_pkg::*;

  logic [7:0] mem_q [FrameBytes];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dsmfd_ctrl.sv =====
// Controller of the frame decoder: byte position, configuration, decode
// sequencer, video transmitter fields and the result register.
// Depends on dsmfd_pkg; drives the frame memory through a ram_req_t bundle.
module dsmfd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dsmfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dsmfd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic [15:0]                   gap_us_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          slot_valid_o,
  output logic [3:0]                    channel_index_o,
  output logic [10:0]                   raw_value_o,
  output logic [10:0]                   scaled_value_o,
  output logic [7:0]                    fade_count_o,
  output logic                          phase_bit_o,
  output logic [4:0]                    vtx_channel_o,
  output logic [2:0]                    vtx_band_o,
  output logic [1:0]                    vtx_power_o,
  output logic                          vtx_region_o,
  output logic                          vtx_pit_o,
  output logic                          last_word_o,
  output dsmfd_pkg::ram_req_t           ram_req_o,
  input  logic [7:0]                    ram_rdata_i
);
  import dsmfd_pkg::*;

  state_e            state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              hires_q, hires_d;
  logic [15:0]       gap_limit_q, gap_limit_d;
  logic [4:0]        vchan_q, vchan_d;
  logic [2:0]        vband_q, vband_d;
  logic [1:0]        vpow_q, vpow_d;
  logic              vreg_q, vreg_d;
  logic              vpit_q, vpit_d;

  // Frame bytes held during a decode.
  logic [7:0]        fade_q, fade_d;
  logic              phase_q, phase_d;
  logic [7:0]        hi_q, hi_d;
  logic [7:0]        b13_q, b13_d;
  logic              mark12_q, mark12_d;
  logic              mark14_q, mark14_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  word_t             word_q, word_d;
  logic [7:0]        ofade_q, ofade_d;
  logic              ophase_q, ophase_d;
  logic [4:0]        ochan_q, ochan_d;
  logic [2:0]        oband_q, oband_d;
  logic [1:0]        opow_q, opow_d;
  logic              oreg_q, oreg_d;
  logic              opit_q, opit_d;
  logic              olast_q, olast_d;

  logic              in_acc;
  logic [PosW-1:0]   pos_eff;
  logic              store_ok;
  logic              frame_done;
  logic              is_lo;
  logic              out_busy;
  logic              cap_stall;

  // Position handling: a long gap restarts the frame at byte zero.
  assign in_acc     = in_valid_i && in_ready_o;
  assign pos_eff    = (gap_us_i > gap_limit_q) ? '0 : pos_q;
  assign store_ok   = (pos_eff < PosW'(FrameBytes));
  assign frame_done = in_acc && (pos_eff == PosW'(FrameBytes - 1));

  // A low word byte completes a result and waits for a free result register.
  assign is_lo     = (step_q >= StepWord0) && !step_q[0];
  assign out_busy  = out_valid_q && !out_ready_i;
  assign cap_stall = (state_q == StCapture) && is_lo && out_busy;

  // Next state of the decode sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (frame_done) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StCapture;
      end
      StCapture: begin
        if (!cap_stall) begin
          state_d = (step_q == StepLast) ? StIdle : StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Handshake and memory port outputs. Input is held off during a decode,
  // so a write never meets a read of the same frame.
  always_comb begin
    cfg_ready_o     = 1'b1;
    in_ready_o      = (state_q == StIdle);
    ram_req_o.we    = in_acc && store_ok;
    ram_req_o.waddr = pos_eff[AddrW-1:0];
    ram_req_o.wdata = rx_byte_i;
    ram_req_o.re    = (state_q == StRead);
    ram_req_o.raddr = step_addr(step_q);
  end

  // Configuration registers.
  always_comb begin
    hires_d     = hires_q;
    gap_limit_d = gap_limit_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgHighRes:  hires_d     = cfg_data_i[0];
        CfgGapLimit: gap_limit_d = cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Byte position.
  always_comb begin
    pos_d = pos_q;
    if (in_acc) begin
      pos_d = store_ok ? pos_eff + 1'b1 : pos_eff;
    end
  end

  // Step counter and capture of the bytes read back.
  always_comb begin
    step_d   = step_q;
    fade_d   = fade_q;
    phase_d  = phase_q;
    hi_d     = hi_q;
    b13_d    = b13_q;
    mark12_d = mark12_q;
    mark14_d = mark14_q;
    vchan_d  = vchan_q;
    vband_d  = vband_q;
    vpow_d   = vpow_q;
    vreg_d   = vreg_q;
    vpit_d   = vpit_q;
    if (state_q == StIdle && frame_done) begin
      step_d = StepFade;
    end
    if (state_q == StCapture && !cap_stall) begin
      step_d = step_q + 1'b1;
      case (step_q)
        StepFade: fade_d   = ram_rdata_i;
        StepB12:  mark12_d = (ram_rdata_i == MarkerByte);
        StepB13:  b13_d    = ram_rdata_i;
        StepB14:  mark14_d = (ram_rdata_i == MarkerByte);
        StepB15: begin
          // Markers update the kept fields before this frame's results.
          if (mark12_q) begin
            vchan_d = {1'b0, b13_q[3:0]} + 5'd1;
            vband_d = b13_q[7:5];
          end
          if (mark14_q) begin
            vpow_d = ram_rdata_i[1:0];
            vreg_d = ram_rdata_i[3];
            vpit_d = ram_rdata_i[4];
          end
        end
        StepWord0: begin
          hi_d    = ram_rdata_i;
          phase_d = ram_rdata_i[7];
        end
        default: begin
          if (step_q[0]) begin
            hi_d = ram_rdata_i;
          end
        end
      endcase
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    word_d      = word_q;
    ofade_d     = ofade_q;
    ophase_d    = ophase_q;
    ochan_d     = ochan_q;
    oband_d     = oband_q;
    opow_d      = opow_q;
    oreg_d      = oreg_q;
    opit_d      = opit_q;
    olast_d     = olast_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == StCapture && is_lo && !out_busy) begin
      out_valid_d = 1'b1;
      word_d      = decode_word(hires_q, hi_q, ram_rdata_i);
      ofade_d     = fade_q;
      ophase_d    = phase_q;
      ochan_d     = vchan_q;
      oband_d     = vband_q;
      opow_d      = vpow_q;
      oreg_d      = vreg_q;
      opit_d      = vpit_q;
      olast_d     = (step_q == StepLast);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= StepFade;
      pos_q       <= '0;
      hires_q     <= 1'b1;
      gap_limit_q <= GapLimitReset;
      vchan_q     <= '0;
      vband_q     <= '0;
      vpow_q      <= '0;
      vreg_q      <= 1'b0;
      vpit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pos_q       <= pos_d;
      hires_q     <= hires_d;
      gap_limit_q <= gap_limit_d;
      vchan_q     <= vchan_d;
      vband_q     <= vband_d;
      vpow_q      <= vpow_d;
      vreg_q      <= vreg_d;
      vpit_q      <= vpit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    fade_q   <= fade_d;
    phase_q  <= phase_d;
    hi_q     <= hi_d;
    b13_q    <= b13_d;
    mark12_q <= mark12_d;
    mark14_q <= mark14_d;
    word_q   <= word_d;
    ofade_q  <= ofade_d;
    ophase_q <= ophase_d;
    ochan_q  <= ochan_d;
    oband_q  <= oband_d;
    opow_q   <= opow_d;
    oreg_q   <= oreg_d;
    opit_q   <= opit_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o     = out_valid_q;
  assign slot_valid_o    = word_q.slot;
  assign channel_index_o = word_q.idx;
  assign raw_value_o     = word_q.raw;
  assign scaled_value_o  = word_q.scaled;
  assign fade_count_o    = ofade_q;
  assign phase_bit_o     = ophase_q;
  assign vtx_channel_o   = ochan_q;
  assign vtx_band_o      = oband_q;
  assign vtx_power_o     = opow_q;
  assign vtx_region_o    = oreg_q;
  assign vtx_pit_o       = opit_q;
  assign last_word_o     = olast_q;

endmodule

// ===== hw/rtl/dsm_serial_frame_decoder_unit.sv =====
// Serial frame decoder, top level. Depends on dsmfd_pkg, dsmfd_frame_ram, dsmfd_ctrl.
// Throughput: one byte request per cycle while no decode runs. The sixteenth byte starts
// a decode (a read state and a capture state per frame memory read); input is held off meanwhile.
// Results: one word per low byte read; a full result register stalls the decode.
// Reset: high resolution on, gap limit 5000, position and video fields cleared; the
// frame memory is not cleared and needs no clearing pass.
module dsm_serial_frame_decoder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dsmfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dsmfd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic [15:0]                    gap_us_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           slot_valid_o,
  output logic [3:0]                     channel_index_o,
  output logic [10:0]                    raw_value_o,
  output logic [10:0]                    scaled_value_o,
  output logic [7:0]                     fade_count_o,
  output logic                           phase_bit_o,
  output logic [4:0]                     vtx_channel_o,
  output logic [2:0]                     vtx_band_o,
  output logic [1:0]                     vtx_power_o,
  output logic                           vtx_region_o,
  output logic                           vtx_pit_o,
  output logic                           last_word_o
);
  import dsmfd_pkg::*;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;

  // Sequencer, position and result register.
  dsmfd_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .gap_us_i        (gap_us_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .slot_valid_o    (slot_valid_o),
    .channel_index_o (channel_index_o),
    .raw_value_o     (raw_value_o),
    .scaled_value_o  (scaled_value_o),
    .fade_count_o    (fade_count_o),
    .phase_bit_o     (phase_bit_o),
    .vtx_channel_o   (vtx_channel_o),
    .vtx_band_o      (vtx_band_o),
    .vtx_power_o     (vtx_power_o),
    .vtx_region_o    (vtx_region_o),
    .vtx_pit_o       (vtx_pit_o),
    .last_word_o     (last_word_o),
    .ram_req_o       (ram_req),
    .ram_rdata_i     (ram_rdata)
  );

  // Frame byte memory.
  dsmfd_frame_ram u_frame_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  // A frame write never overlaps a decode read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("frame memory written during a decode read");

  // No byte request is taken in a cycle that reads the frame memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !ram_req.re)
    else $error("byte accepted while decoding");

  // Scaled values stay in the legal servo range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (scaled_value_o >= 11'd988 && scaled_value_o <= 11'd2011))
    else $error("scaled value out of range");
`endif

endmodule

// ===== bench/dsm_serial_frame_decoder_unit_test.sv =====
// Self-checking testbench for the serial frame decoder top level.
// Depends on dsmfd_pkg and dsm_serial_frame_decoder_unit with its submodules.
// Runs directed and random byte streams in several register settings.
module dsm_serial_frame_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dsmfd_pkg::*;

  localparam int unsigned WordsPerFrame     = 7;
  localparam int unsigned RandomBytesTarget = 320;
  localparam int unsigned LongHoldCycles    = 400;
  localparam int unsigned DrainCycles       = 60;
  localparam logic [CfgIdxW-1:0] CfgSpareA  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB  = 2'd3;

  // One received byte with the idle time that preceded it.
  typedef struct packed {
    logic [7:0]  rx;
    logic [15:0] gap;
  } serial_byte_t;

  // One decoded channel word as the block reports it.
  typedef struct packed {
    logic        slot;
    logic [3:0]  chan;
    logic [10:0] raw;
    logic [10:0] scaled;
    logic [7:0]  fades;
    logic        phase;
    logic [4:0]  vtx_chan;
    logic [2:0]  vtx_band;
    logic [1:0]  vtx_pwr;
    logic        vtx_region;
    logic        vtx_pit;
    logic        last;
  } channel_word_t;

  typedef enum int {
    ReadyAlways,
    ReadyRandom,
    ReadyPattern
  } ready_style_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = '0;
  logic [15:0]         in_gap = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                slot_valid;
  logic [3:0]          channel_index;
  logic [10:0]         raw_value;
  logic [10:0]         scaled_value;
  logic [7:0]          fade_count;
  logic                phase_bit;
  logic [4:0]          vtx_channel;
  logic [2:0]          vtx_band;
  logic [1:0]          vtx_power;
  logic                vtx_region;
  logic                vtx_pit;
  logic                last_word;

  // Decoder state as the testbench expects it to be.
  logic                cfg_high_res = 1'b1;
  logic [15:0]         cfg_gap_limit = GapLimitReset;
  logic [7:0]          frame_bytes [FrameBytes];
  int unsigned         frame_fill = 0;
  logic [4:0]          kept_vtx_chan = '0;
  logic [2:0]          kept_vtx_band = '0;
  logic [1:0]          kept_vtx_pwr = '0;
  logic                kept_vtx_region = 1'b0;
  logic                kept_vtx_pit = 1'b0;

  serial_byte_t        pending_bytes[$];
  channel_word_t       expected_words[$];
  int unsigned         bytes_queued = 0;
  int unsigned         bytes_accepted = 0;
  int unsigned         words_checked = 0;
  int unsigned         frames_decoded = 0;
  int unsigned         mismatch_count = 0;

  // Idle control shared between the stimulus sequence and the two sides.
  bit                  sender_bursty = 1'b0;
  int unsigned         burst_left = 0;
  int unsigned         gap_left = 0;
  ready_style_e        ready_style = ReadyAlways;
  logic [7:0]          ready_pattern = 8'hFF;
  logic [2:0]          pattern_pos = '0;
  int unsigned         hold_requests = 0;
  int unsigned         holds_served = 0;
  int unsigned         hold_left = 0;

  dsm_serial_frame_decoder_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (in_byte),
    .gap_us_i        (in_gap),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .slot_valid_o    (slot_valid),
    .channel_index_o (channel_index),
    .raw_value_o     (raw_value),
    .scaled_value_o  (scaled_value),
    .fade_count_o    (fade_count),
    .phase_bit_o     (phase_bit),
    .vtx_channel_o   (vtx_channel),
    .vtx_band_o      (vtx_band),
    .vtx_power_o     (vtx_power),
    .vtx_region_o    (vtx_region),
    .vtx_pit_o       (vtx_pit),
    .last_word_o     (last_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Prints one line per mismatch and counts them all.
  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] seen);
    mismatch_count++;
    $display("mismatch at %0t ns: %s expected %0d got %0d (word %0d)",
             $time, what, want, seen, words_checked);
  endtask

  // Tracks the frame position for one accepted byte and, on the sixteenth
  // byte, queues the seven channel words that the frame decodes into.
  task automatic absorb_rx_byte(input serial_byte_t sb);
    int unsigned   k;
    int unsigned   hi;
    int unsigned   lo;
    int unsigned   shift;
    int unsigned   mask;
    int unsigned   id;
    int unsigned   raw;
    channel_word_t w;
    if (sb.gap > cfg_gap_limit) frame_fill = 0;
    if (frame_fill < FrameBytes) begin
      frame_bytes[frame_fill] = sb.rx;
      frame_fill++;
      if (frame_fill == FrameBytes) begin
        frames_decoded++;
        // Marker bytes refresh the kept video fields before the words go out.
        if (frame_bytes[12] == MarkerByte) begin
          kept_vtx_chan = {1'b0, frame_bytes[13][3:0]} + 5'd1;
          kept_vtx_band = frame_bytes[13][7:5];
        end
        if (frame_bytes[14] == MarkerByte) begin
          kept_vtx_pwr    = frame_bytes[15][1:0];
          kept_vtx_region = frame_bytes[15][3];
          kept_vtx_pit    = frame_bytes[15][4];
        end
        shift = cfg_high_res ? 3 : 2;
        mask  = cfg_high_res ? 32'h07 : 32'h03;
        for (k = 0; k < WordsPerFrame; k++) begin
          hi  = frame_bytes[2 + 2 * k];
          lo  = frame_bytes[3 + 2 * k];
          id  = (hi >> shift) & 32'h0F;
          raw = ((hi & mask) << 8) + lo;
          w.slot       = id < (cfg_high_res ? HiChannels : LoChannels);
          w.chan       = 4'(id);
          w.raw        = 11'(raw);
          w.scaled     = 11'(ScaleBase + (cfg_high_res ? (raw >> 1) : raw));
          w.fades      = frame_bytes[0];
          w.phase      = frame_bytes[2][7];
          w.vtx_chan   = kept_vtx_chan;
          w.vtx_band   = kept_vtx_band;
          w.vtx_pwr    = kept_vtx_pwr;
          w.vtx_region = kept_vtx_region;
          w.vtx_pit    = kept_vtx_pit;
          w.last       = (k == WordsPerFrame - 1);
          expected_words.push_back(w);
        end
      end
    end
  endtask

  // Register write; must be called while the decoder is idle.
  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [CfgDataW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      CfgHighRes:  cfg_high_res  = value[0];
      CfgGapLimit: cfg_gap_limit = value;
      default: ;
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] rx, input logic [15:0] gap);
    pending_bytes.push_back('{rx: rx, gap: gap});
    bytes_queued++;
  endtask

  // Idle time that keeps the frame going under the current limit.
  function automatic logic [15:0] inner_gap();
    int unsigned pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0:       return 16'd0;
      1:       return cfg_gap_limit;
      default: return 16'($urandom_range(0, cfg_gap_limit));
    endcase
  endfunction

  // Idle time that restarts the frame; the limit is below 65535 here.
  function automatic logic [15:0] start_gap();
    int unsigned pick;
    int unsigned floor_gap;
    pick      = $urandom_range(0, 3);
    floor_gap = cfg_gap_limit + 1;
    case (pick)
      0:       return 16'(floor_gap);
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(floor_gap, 65535));
    endcase
  endfunction

  // Queues len bytes that fill frame slots first_pos onward, with random
  // content and a video marker now and then at bytes 12 and 14.
  task automatic queue_frame(input int unsigned len, input int unsigned first_pos,
                             input bit restart);
    int unsigned i;
    int unsigned pos;
    logic [7:0]  rx;
    logic [15:0] gap;
    for (i = 0; i < len; i++) begin
      pos = first_pos + i;
      rx  = 8'($urandom);
      if ((pos == 12 || pos == 14) && $urandom_range(0, 2) == 0) rx = MarkerByte;
      gap = (i == 0 && restart) ? start_gap() : inner_gap();
      queue_byte(rx, gap);
    end
  endtask

  // Lets every queued byte in, waits for every expected word, then lets
  // the decoder settle before any register is touched.
  task automatic finish_phase();
    while (bytes_accepted != bytes_queued) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Sender: bytes come from the pending queue, in bursts when enabled.
  always @(posedge clk) begin : byte_sender
    serial_byte_t next_byte;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        absorb_rx_byte('{rx: in_byte, gap: in_gap});
        bytes_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte  <= next_byte.rx;
          in_gap   <= next_byte.gap;
          if (sender_bursty) begin
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 24);
              gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 8);
            end else begin
              burst_left--;
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a long hold-off on request, otherwise the phase's stall style.
  always @(posedge clk) begin : word_receiver
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= LongHoldCycles;
      out_ready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (ready_style)
        ReadyRandom:  out_ready <= ($urandom_range(0, 3) != 0);
        ReadyPattern: out_ready <= ready_pattern[pattern_pos];
        default:      out_ready <= 1'b1;
      endcase
      pattern_pos <= pattern_pos + 3'd1;
    end
  end

  // Checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin : word_checker
    channel_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing pending, channel_index", '0, channel_index);
      end else begin
        want = expected_words.pop_front();
        if (slot_valid !== want.slot)
          report_mismatch("slot_valid", want.slot, slot_valid);
        if (channel_index !== want.chan)
          report_mismatch("channel_index", want.chan, channel_index);
        if (raw_value !== want.raw)
          report_mismatch("raw_value", want.raw, raw_value);
        if (scaled_value !== want.scaled)
          report_mismatch("scaled_value", want.scaled, scaled_value);
        if (fade_count !== want.fades)
          report_mismatch("fade_count", want.fades, fade_count);
        if (phase_bit !== want.phase)
          report_mismatch("phase_bit", want.phase, phase_bit);
        if (vtx_channel !== want.vtx_chan)
          report_mismatch("vtx_channel", want.vtx_chan, vtx_channel);
        if (vtx_band !== want.vtx_band)
          report_mismatch("vtx_band", want.vtx_band, vtx_band);
        if (vtx_power !== want.vtx_pwr)
          report_mismatch("vtx_power", want.vtx_pwr, vtx_power);
        if (vtx_region !== want.vtx_region)
          report_mismatch("vtx_region", want.vtx_region, vtx_region);
        if (vtx_pit !== want.vtx_pit)
          report_mismatch("vtx_pit", want.vtx_pit, vtx_pit);
        if (last_word !== want.last)
          report_mismatch("last_word", want.last, last_word);
        words_checked++;
      end
    end
  end

  // Stimulus sequence: reset, a directed frame, then random phases.
  initial begin : stimulus
    int unsigned phase_num;
    int unsigned random_bytes;
    int unsigned f;
    int unsigned len;
    logic        hires;
    logic [15:0] limit;
    phase_num    = 0;
    random_bytes = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frame at the reset settings: extreme words, an id just
    // inside and just outside the channel count, both video markers.
    sender_bursty = 1'b1;
    ready_style   = ReadyRandom;
    write_register(CfgSpareA, 16'($urandom));
    write_register(CfgHighRes, 16'hFFFF);
    write_register(CfgGapLimit, GapLimitReset);
    queue_byte(8'hFF, 16'hFFFF);
    queue_byte(8'h00, GapLimitReset);
    queue_byte(8'hFF, 16'd0);
    queue_byte(8'hFF, 16'd1);
    queue_byte(8'h00, 16'd4999);
    queue_byte(8'h00, 16'd0);
    queue_byte(8'h58, GapLimitReset);
    queue_byte(8'h80, 16'd0);
    queue_byte(8'h60, 16'd17);
    queue_byte(8'h01, 16'd0);
    queue_byte(8'h07, 16'd2500);
    queue_byte(8'hFF, 16'd0);
    queue_byte(MarkerByte, 16'd0);
    queue_byte(8'hFF, 16'd0);
    queue_byte(MarkerByte, 16'd0);
    queue_byte(8'h1B, 16'd0);
    // A full frame drops further bytes until a long gap restarts it.
    queue_byte(8'h5A, 16'd0);
    queue_byte(8'hA5, GapLimitReset);
    queue_byte(8'h3C, GapLimitReset + 16'd1);
    finish_phase();

    // Random phases, each with its own settings and idle behavior.
    while (random_bytes < RandomBytesTarget) begin
      case (phase_num)
        0: begin hires = 1'b0; limit = GapLimitReset; end
        1: begin hires = 1'b1; limit = 16'd0; end
        2: begin hires = 1'b0; limit = 16'hFFFF; end
        3: begin hires = 1'b1; limit = 16'($urandom_range(1, 65534)); end
        4: begin hires = 1'b0; limit = 16'd0; end
        5: begin hires = 1'b1; limit = 16'hFFFF; end
        6: begin hires = 1'b0; limit = 16'($urandom_range(1, 200)); end
        default: begin
          hires = 1'($urandom);
          limit = 16'($urandom_range(0, 65534));
        end
      endcase
      write_register(CfgHighRes, (16'($urandom) & 16'hFFFE) | {15'd0, hires});
      write_register(CfgGapLimit, limit);
      if (phase_num == 3) write_register(CfgSpareB, 16'($urandom));

      if (phase_num == 0) begin
        sender_bursty = 1'b0;
        ready_style   = ReadyAlways;
      end else begin
        sender_bursty = 1'($urandom);
        ready_style   = ready_style_e'($urandom_range(0, 2));
        ready_pattern = 8'($urandom) | 8'h01;
      end
      if (phase_num == 1) hold_requests <= hold_requests + 1;

      if (cfg_gap_limit == 16'hFFFF) begin
        // No gap can restart here: finish the frame left open, then noise.
        len = FrameBytes - frame_fill;
        queue_frame(len, frame_fill, 1'b0);
        random_bytes += len;
        queue_frame(2, FrameBytes, 1'b0);
      end else begin
        for (f = 0; f < 3; f++) begin
          if ($urandom_range(0, 4) != 0) begin
            queue_frame(FrameBytes, 0, 1'b1);
            random_bytes += FrameBytes;
            if ($urandom_range(0, 2) == 0) queue_frame($urandom_range(1, 3), FrameBytes, 1'b0);
          end else begin
            len = $urandom_range(1, 15);
            queue_frame(len, 0, 1'b1);
            random_bytes += len;
          end
        end
        // Leave a frame open across the next settings change.
        len = $urandom_range(1, 10);
        queue_frame(len, 0, 1'b1);
        random_bytes += len;
      end
      finish_phase();
      phase_num++;
    end

    $display("Run: %0d bytes over %0d random phases, %0d frames decoded, %0d words checked.",
             bytes_accepted, phase_num, frames_decoded, words_checked);
    $display("Both resolutions, gap limits 0 to 65535, video markers, dropped and cut frames.");
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a stuck handshake or a missing word.
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d words still pending", expected_words.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
